// File: rtl/ihsp_pkg.sv
// Shared types, constants and helper functions for the image header size parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ihsp_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIM_W    = 32;
    localparam int unsigned FMT_W    = 2;
    localparam int unsigned HDR_LEN  = 24;
    localparam int unsigned WIN_LEN  = 12;

    // Image format codes
    localparam logic [FMT_W-1:0] FMT_JPEG = 2'd0;
    localparam logic [FMT_W-1:0] FMT_GIF  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_PNG  = 2'd2;
    localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;

    // Status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Marker and signature bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_APP0   = 8'hE0;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOF1   = 8'hC1;
    localparam logic [7:0] MARK_SOF2   = 8'hC2;
    localparam logic [7:0] MARK_SOF3   = 8'hC3;
    localparam logic [7:0] MARK_SOF9   = 8'hC9;
    localparam logic [7:0] MARK_SOF10  = 8'hCA;
    localparam logic [7:0] MARK_SOF11  = 8'hCB;
    localparam logic [7:0] PNG_SIG0    = 8'h89;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_SUB   = 8'h1A;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_G        = 8'h47;
    localparam logic [7:0] CH_P        = 8'h50;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_R        = 8'h52;

    // Storage shapes: element 0 is the first byte
    typedef logic [HDR_LEN-1:0][7:0] hdr_t;
    typedef logic [WIN_LEN-1:0][7:0] win_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DECIDE,
        PH_HWALK,
        PH_WALK,
        PH_DONE
    } phase_t;

    // One result
    typedef struct packed {
        logic             status;
        logic [FMT_W-1:0] fmt;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } answer_t;

    // Header classification
    typedef struct packed {
        logic    is_jfif;
        answer_t ans;
    } hdr_dec_t;

    // Outcome of examining one segment window
    typedef struct packed {
        logic        bad_marker;
        logic        sof;
        logic        past_end;
        logic        fits_hdr;
        logic [31:0] next_start;
    } step_t;

    localparam answer_t ANS_ERROR = '{status: STAT_ERR, fmt: FMT_NONE,
                                      width: '0, height: '0};

    function automatic logic is_sof(input logic [7:0] m);
        return (m == MARK_SOF0) || (m == MARK_SOF1) || (m == MARK_SOF2) ||
               (m == MARK_SOF3) || (m == MARK_SOF9) || (m == MARK_SOF10) ||
               (m == MARK_SOF11);
    endfunction

    // JPEG frame header: height first, then width, both big endian
    function automatic answer_t jpeg_answer(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        answer_t a;
        a.status = STAT_OK;
        a.fmt    = FMT_JPEG;
        a.height = {16'd0, b0, b1};
        a.width  = {16'd0, b2, b3};
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/image_header_size_parser_top.sv
// Top level of the image header size parser: parser state, phase control and ports.
// Depends on ihsp_pkg, ihsp_in_reg, ihsp_hdr_decode, ihsp_seg_step, ihsp_out_reg.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata[7:0] data_byte; tlast last_byte
//   m_       out        tdata[31:0] image_width, [63:32] image_height;
//                       tuser[0] status, [2:1] image_format
//   cfg_     in         cfg_wdata file_length, written when cfg_we is high
//
// One byte is taken per cycle while the parser is not stalled by a full output register.
// After the 24th byte no byte is taken while the header is classified; a JFIF file also
// waits while each JPEG segment window that starts inside the header is examined.
// A byte beat is registered in the input register before the parser processes it, and
// a result is offered on m_ in the cycle after the parser reaches its answer.
// Reset is synchronous and active low and returns the parser to header collection.
// A stalled output only holds the parser when a new result is ready to be loaded.
`timescale 1ns / 1ps
`default_nettype none

module image_header_size_parser_top
    import ihsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] image_width, [63:32] image_height
    output logic [2:0]       m_tuser,   // [0] status, [2:1] image_format
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    // Parser state
    logic [31:0] file_length_reg;
    phase_t      phase_reg,     phase_next;
    logic [31:0] bp_reg,        bp_next;
    logic [31:0] ss_reg,        ss_next;
    hdr_t        hdr_reg,       hdr_next;
    win_t        win_reg,       win_next;
    logic        last_pend_reg, last_pend_next;

    // Core control
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        in_take;
    logic        act;
    logic        uses_input;
    logic        produce;
    logic        clear;
    logic        go;
    logic        out_free;
    logic        out_load;
    answer_t     ans;
    hdr_dec_t    dec;
    step_t       step;
    win_t        step_win;
    win_t        step_new;
    logic        step_from_hdr;
    win_t        win_upd;
    logic [31:0] bp_inc;
    logic [31:0] rel;
    logic        in_win;
    logic        walk_due;

    ihsp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (in_take),
        .item_valid (in_valid),
        .item_byte  (in_byte),
        .item_last  (in_last)
    );

    ihsp_hdr_decode u_dec (
        .hdr (hdr_reg),
        .dec (dec)
    );

    ihsp_seg_step u_step (
        .win         (step_win),
        .seg_start   (ss_reg),
        .file_length (file_length_reg),
        .hdr         (hdr_reg),
        .from_hdr    (step_from_hdr),
        .step        (step),
        .next_win    (step_new)
    );

    ihsp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .ans      (ans),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (cfg_we) begin
            file_length_reg <= cfg_wdata;
        end
    end

    // Byte position arithmetic; the position saturates at its maximum.
    assign bp_inc   = (bp_reg == '1) ? bp_reg : bp_reg + 32'd1;
    assign rel      = bp_reg - ss_reg;
    assign in_win   = (bp_reg >= ss_reg) && (rel < 32'(WIN_LEN));
    assign walk_due = in_win && (rel[3:0] == 4'(WIN_LEN - 1));

    // Current window with the incoming byte merged in
    always_comb begin
        win_upd = win_reg;
        if (in_win) begin
            win_upd[rel[3:0]] = in_byte;
        end
    end

    // Next state and result selection
    always_comb begin
        phase_next     = phase_reg;
        bp_next        = bp_reg;
        ss_next        = ss_reg;
        hdr_next       = hdr_reg;
        win_next       = win_reg;
        last_pend_next = last_pend_reg;
        act            = 1'b0;
        uses_input     = 1'b0;
        produce        = 1'b0;
        clear          = 1'b0;
        ans            = ANS_ERROR;
        step_win       = win_reg;
        step_from_hdr  = 1'b1;

        unique case (phase_reg)
            PH_HEADER: begin
                act        = in_valid;
                uses_input = 1'b1;
                if (file_length_reg < 32'(HDR_LEN)) begin
                    produce    = 1'b1;
                    phase_next = PH_DONE;
                    clear      = in_last;
                end else begin
                    hdr_next[bp_reg[4:0]] = in_byte;
                    bp_next               = bp_inc;
                    if (bp_reg[4:0] == 5'(HDR_LEN - 1)) begin
                        // Last header byte: its end-of-file flag waits for the decision.
                        phase_next     = PH_DECIDE;
                        last_pend_next = in_last;
                    end else if (in_last) begin
                        produce = 1'b1;
                        clear   = 1'b1;
                    end
                end
            end

            PH_DECIDE: begin
                act = 1'b1;
                if (dec.is_jfif) begin
                    win_next   = hdr_reg[13:2];
                    ss_next    = 32'd2;
                    phase_next = PH_HWALK;
                end else begin
                    produce    = 1'b1;
                    ans        = dec.ans;
                    phase_next = PH_DONE;
                    clear      = last_pend_reg;
                end
            end

            PH_HWALK: begin
                // Hop over segments that lie wholly inside the header, one per cycle.
                act = 1'b1;
                if (step.bad_marker) begin
                    produce    = 1'b1;
                    phase_next = PH_DONE;
                    clear      = last_pend_reg;
                end else if (step.sof || step.past_end) begin
                    produce    = 1'b1;
                    ans        = jpeg_answer(win_reg[5], win_reg[6], win_reg[7], win_reg[8]);
                    phase_next = PH_DONE;
                    clear      = last_pend_reg;
                end else begin
                    win_next = step_new;
                    ss_next  = step.next_start;
                    if (!step.fits_hdr) begin
                        phase_next = PH_WALK;
                        if (last_pend_reg) begin
                            produce = 1'b1;
                            clear   = 1'b1;
                        end
                    end
                end
            end

            PH_WALK: begin
                act           = in_valid;
                uses_input    = 1'b1;
                win_next      = win_upd;
                bp_next       = bp_inc;
                step_win      = win_upd;
                step_from_hdr = 1'b0;
                if (walk_due) begin
                    if (step.bad_marker) begin
                        produce    = 1'b1;
                        phase_next = PH_DONE;
                    end else if (step.sof || step.past_end) begin
                        produce    = 1'b1;
                        ans        = jpeg_answer(win_upd[5], win_upd[6], win_upd[7],
                                                 win_upd[8]);
                        phase_next = PH_DONE;
                    end else begin
                        win_next = step_new;
                        ss_next  = step.next_start;
                    end
                end
                // End of file without an answer is an error.
                if (in_last) begin
                    produce = 1'b1;
                    clear   = 1'b1;
                end
            end

            PH_DONE: begin
                act        = in_valid;
                uses_input = 1'b1;
                clear      = in_last;
            end

            default: begin
                act = 1'b0;
            end
        endcase

        // The final byte of a file returns the parser to header collection.
        if (clear) begin
            phase_next     = PH_HEADER;
            bp_next        = '0;
            ss_next        = 32'd2;
            last_pend_next = 1'b0;
        end
    end

    // Advance unless a result is due and the output register is still full.
    assign go       = act && (!produce || out_free);
    assign in_take  = go && uses_input;
    assign out_load = go && produce;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            bp_reg        <= '0;
            ss_reg        <= 32'd2;
            last_pend_reg <= 1'b0;
        end else if (go) begin
            phase_reg     <= phase_next;
            bp_reg        <= bp_next;
            ss_reg        <= ss_next;
            last_pend_reg <= last_pend_next;
        end
    end

    // Byte stores; every byte is written before it is read.
    always_ff @(posedge aclk) begin
        if (go) begin
            hdr_reg <= hdr_next;
            win_reg <= win_next;
        end
    end

    // A result is never loaded over one that has not left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded while output register is occupied");

    // Header collection never runs past the header length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (bp_reg < 32'(HDR_LEN)))
        else $error("header position out of range");

    // While streaming, the current window is never already complete.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WALK) |-> ({1'b0, bp_reg} < ({1'b0, ss_reg} + 33'(WIN_LEN))))
        else $error("segment window complete but not examined");

    // A deferred end-of-file flag lives only while the header is being decided.
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_pend_reg |-> ((phase_reg == PH_DECIDE) || (phase_reg == PH_HWALK)))
        else $error("pending end of file outside header decision");

endmodule

`default_nettype wire

// File: rtl/ihsp_in_reg.sv
// Input register for the byte stream: holds one beat until the parser core takes it.
// Depends on ihsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihsp_in_reg
    import ihsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        take,
    output logic             item_valid,
    output logic [7:0]       item_byte,
    output logic             item_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // A new beat may enter when the register is empty or is emptied this cycle.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihsp_hdr_decode.sv
// Classifies the first 24 bytes of a file and decodes GIF, PNG and plain JPEG sizes.
// Depends on ihsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihsp_hdr_decode
    import ihsp_pkg::*;
(
    input  wire hdr_t hdr,
    output hdr_dec_t  dec
);

    logic jpeg_sig;
    logic jfif_sig;
    logic gif_sig;
    logic png_sig;

    // Signature compares
    assign jpeg_sig = (hdr[0] == MARK_PREFIX) && (hdr[1] == MARK_SOI) &&
                      (hdr[2] == MARK_PREFIX);
    assign jfif_sig = jpeg_sig && (hdr[3] == MARK_APP0) && (hdr[6] == CH_J) &&
                      (hdr[7] == CH_F) && (hdr[8] == CH_I) && (hdr[9] == CH_F);
    assign gif_sig  = (hdr[0] == CH_G) && (hdr[1] == CH_I) && (hdr[2] == CH_F);
    assign png_sig  = (hdr[0] == PNG_SIG0) && (hdr[1] == CH_P) && (hdr[2] == CH_N) &&
                      (hdr[3] == CH_G) && (hdr[4] == ASCII_CR) && (hdr[5] == ASCII_LF) &&
                      (hdr[6] == ASCII_SUB) && (hdr[7] == ASCII_LF) &&
                      (hdr[12] == CH_I) && (hdr[13] == CH_H) && (hdr[14] == CH_D) &&
                      (hdr[15] == CH_R);

    // Priority follows the format checks: JFIF, other JPEG, GIF, PNG.
    always_comb begin
        dec.is_jfif = jfif_sig;
        dec.ans     = ANS_ERROR;
        if (jpeg_sig) begin
            dec.ans = jpeg_answer(hdr[7], hdr[8], hdr[9], hdr[10]);
        end else if (gif_sig) begin
            dec.ans.status = STAT_OK;
            dec.ans.fmt    = FMT_GIF;
            dec.ans.width  = {16'd0, hdr[7], hdr[6]};
            dec.ans.height = {16'd0, hdr[9], hdr[8]};
        end else if (png_sig) begin
            dec.ans.status = STAT_OK;
            dec.ans.fmt    = FMT_PNG;
            dec.ans.width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
            dec.ans.height = {hdr[20], hdr[21], hdr[22], hdr[23]};
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihsp_seg_step.sv
// Examines one 12-byte JPEG segment window and forms the window of the next segment.
// Depends on ihsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihsp_seg_step
    import ihsp_pkg::*;
(
    input  wire win_t        win,
    input  wire logic [31:0] seg_start,
    input  wire logic [31:0] file_length,
    input  wire hdr_t        hdr,
    input  wire logic        from_hdr,
    output step_t            step,
    output win_t             next_win
);

    logic [15:0] seg_len;
    logic [32:0] next_pos;
    logic [33:0] next_end;
    logic [17:0] hop;
    logic [32:0] hpos [WIN_LEN];
    logic [17:0] wpos [WIN_LEN];

    assign seg_len  = {win[2], win[3]};
    assign next_pos = 33'(seg_start) + 33'(seg_len) + 33'd2;
    assign next_end = 34'(next_pos) + 34'(WIN_LEN);
    assign hop      = 18'(seg_len) + 18'd2;

    // Window verdict
    assign step.bad_marker = (win[0] != MARK_PREFIX);
    assign step.sof        = is_sof(win[1]);
    assign step.past_end   = (next_end > 34'(file_length));
    assign step.fits_hdr   = (next_end <= 34'(HDR_LEN));
    assign step.next_start = next_pos[31:0];

    // Next window: while still inside the header all bytes come from the header
    // store; in the stream they come from the overlap with the current window.
    // Bytes not yet received read as zero until the stream fills them.
    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            hpos[i]     = next_pos + 33'(i);
            wpos[i]     = hop + 18'(i);
            next_win[i] = 8'd0;
            if (from_hdr) begin
                if (hpos[i] < 33'(HDR_LEN)) begin
                    next_win[i] = hdr[hpos[i][4:0]];
                end
            end else if (wpos[i] < 18'(WIN_LEN)) begin
                next_win[i] = win[wpos[i][3:0]];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihsp_out_reg.sv
// Result register: holds one result beat until the downstream side takes it.
// Depends on ihsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihsp_out_reg
    import ihsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire answer_t     ans,
    output logic             free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    logic    valid_reg;
    answer_t ans_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {ans_reg.height, ans_reg.width};
    assign m_tuser  = {ans_reg.fmt, ans_reg.status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            ans_reg <= ans;
        end
    end

endmodule

`default_nettype wire
